>>> sv/fpsqrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpsqrt_pkg;

  // Width of the operand, the root and the internal remainder.
  localparam int unsigned DataW = 32;
  // Width of the fractional bit count register.
  localparam int unsigned FracW = 5;

  // The root search works with this many fractional bits internally.
  localparam logic [FracW-1:0] InternalFrac = 5'd16;

  // Number of radix-2 digit cells in each of the two phases.
  localparam int unsigned Phase1Cells = 16;
  localparam int unsigned Phase2Cells = 8;

  // Largest remainder that can be shifted up by 16 without the half-bit fix.
  localparam logic [DataW-1:0] RemLimit = 32'd65535;
  // Half of the lowest root bit after the phase change.
  localparam logic [DataW-1:0] HalfBit = 32'h0000_8000;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgFracBits = 1'b0,
    CfgRoundEn  = 1'b1
  } cfg_idx_e;

  // Everything that travels down the chain with one item.
  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] root;
    logic             neg;
    logic [FracW-1:0] frac;
    logic             rnd;
  } stage_t;

endpackage

`default_nettype wire

>>> sv/fixed_point_square_root.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed fixed-point square root.
//
// An item is taken on the rising clock edge where start is high and busy is
// low. value_i holds a signed 32-bit operand with frac_bits fractional bits;
// the result root_o has the same format and is the root of the magnitude,
// negated when the operand is negative. The frac_bits and round_enable
// registers are written through cfg_we_i / cfg_idx_i / cfg_data_i and are
// sampled together with each item, so later writes never disturb items that
// are already in flight.
//
// The item passes through an input stage, a chain of 16 digit cells for the
// integer phase, a phase change stage, 8 more digit cells for the fraction
// phase, a rounding stage and an output stage. root_o and root_valid_o come
// from the output stage registers, for exactly one cycle. The chain moves
// every cycle, so busy stays low and one item can enter per cycle.
// The receiver cannot hold results off, so nothing ever stalls.
//
// Reset clears all valid flags in the chain and loads frac_bits = 16 and
// round_enable = 1.
module fixed_point_square_root (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      start,
  output logic                                           busy,
  input  wire logic signed [fpsqrt_pkg::DataW-1:0]       value_i,
  output logic                                           root_valid_o,
  output logic signed [fpsqrt_pkg::DataW-1:0]            root_o,
  input  wire logic                                      cfg_we_i,
  input  wire fpsqrt_pkg::cfg_idx_e                      cfg_idx_i,
  input  wire logic [fpsqrt_pkg::FracW-1:0]              cfg_data_i
);
  import fpsqrt_pkg::*;

  // Configuration registers.
  logic [FracW-1:0] frac_q;
  logic             rnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= InternalFrac;
      rnd_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFracBits: frac_q <= cfg_data_i;
        CfgRoundEn:  rnd_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The chain never stalls, so a new item is welcome in every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Input stage: take the magnitude and rescale it to 16 fractional bits.
  // Bits pushed beyond bit 31 are lost, as are bits shifted out below bit 0.
  logic [DataW-1:0] mag;
  logic [DataW-1:0] scaled;
  logic [FracW-1:0] in_shift;
  stage_t           in_d;
  stage_t           in_q;
  logic             in_valid_q;

  always_comb begin
    mag = value_i[DataW-1] ? (DataW'(0) - DataW'(value_i)) : DataW'(value_i);
    if (frac_q < InternalFrac) begin
      in_shift = InternalFrac - frac_q;
      scaled   = mag << in_shift;
    end else begin
      in_shift = frac_q - InternalFrac;
      scaled   = mag >> in_shift;
    end
    in_d.rem  = scaled;
    in_d.root = '0;
    in_d.neg  = value_i[DataW-1];
    in_d.frac = frac_q;
    in_d.rnd  = rnd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  // Integer phase: one cell per radix-2 digit, bit weight from 2^30 down to 1.
  // Leading cells whose bit exceeds the remainder leave a zero root untouched,
  // so starting every item at the top bit gives the same root.
  stage_t p1_data  [Phase1Cells+1];
  logic   p1_valid [Phase1Cells+1];

  assign p1_data[0]  = in_q;
  assign p1_valid[0] = in_valid_q;

  for (genvar i = 0; i < Phase1Cells; i++) begin : g_phase1
    fpsqrt_cell #(
      .BitShift(2 * (Phase1Cells - 1 - i))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(p1_valid[i]),
      .data_i (p1_data[i]),
      .valid_o(p1_valid[i+1]),
      .data_o (p1_data[i+1])
    );
  end

  // Phase change: shift remainder and root up by 16. A remainder too large
  // for that shift first gives up one root and takes the half-bit correction.
  stage_t mid_d;
  stage_t mid_q;
  logic   mid_valid_q;

  always_comb begin
    mid_d = p1_data[Phase1Cells];
    if (p1_data[Phase1Cells].rem > RemLimit) begin
      mid_d.rem  = ((p1_data[Phase1Cells].rem - p1_data[Phase1Cells].root) << 16) - HalfBit;
      mid_d.root = (p1_data[Phase1Cells].root << 16) + HalfBit;
    end else begin
      mid_d.rem  = p1_data[Phase1Cells].rem << 16;
      mid_d.root = p1_data[Phase1Cells].root << 16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= p1_valid[Phase1Cells];
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
  end

  // Fraction phase: bit weight from 2^14 down to 1.
  stage_t p2_data  [Phase2Cells+1];
  logic   p2_valid [Phase2Cells+1];

  assign p2_data[0]  = mid_q;
  assign p2_valid[0] = mid_valid_q;

  for (genvar j = 0; j < Phase2Cells; j++) begin : g_phase2
    fpsqrt_cell #(
      .BitShift(2 * (Phase2Cells - 1 - j))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(p2_valid[j]),
      .data_i (p2_data[j]),
      .valid_o(p2_valid[j+1]),
      .data_o (p2_data[j+1])
    );
  end

  // Rounding stage: when rounding is enabled, add one when the remainder exceeds the root.
  stage_t tail;
  stage_t rnd_stage_d;
  stage_t rnd_stage_q;
  logic   rnd_valid_q;

  assign tail = p2_data[Phase2Cells];

  always_comb begin
    rnd_stage_d = tail;
    if (tail.rnd && (tail.rem > tail.root)) begin
      rnd_stage_d.root = tail.root + DataW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
    end else begin
      rnd_valid_q <= p2_valid[Phase2Cells];
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_stage_q <= rnd_stage_d;
  end

  // Output stage: rescale back to the item's fractional bits and restore
  // the sign.
  logic [FracW-1:0] out_shift;
  logic [DataW-1:0] rescaled;
  logic [DataW-1:0] root_d;
  logic [DataW-1:0] root_q;
  logic             out_valid_q;

  always_comb begin
    if (rnd_stage_q.frac < InternalFrac) begin
      out_shift = InternalFrac - rnd_stage_q.frac;
      rescaled  = rnd_stage_q.root >> out_shift;
    end else begin
      out_shift = rnd_stage_q.frac - InternalFrac;
      rescaled  = rnd_stage_q.root << out_shift;
    end
    root_d = rnd_stage_q.neg ? (DataW'(0) - rescaled) : rescaled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= rnd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
  end

  assign root_valid_o = out_valid_q;
  assign root_o       = root_q;

endmodule

`default_nettype wire

>>> sv/fpsqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One restoring square root step: trial subtract of root plus the current bit.
module fpsqrt_cell #(
  parameter int unsigned BitShift = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire fpsqrt_pkg::stage_t  data_i,
  output logic                     valid_o,
  output fpsqrt_pkg::stage_t       data_o
);
  import fpsqrt_pkg::*;

  localparam logic [DataW-1:0] Bit = DataW'(1) << BitShift;

  logic [DataW-1:0] trial;
  stage_t           data_d;
  stage_t           data_q;
  logic             valid_q;

  assign trial = data_i.root + Bit;

  always_comb begin
    data_d = data_i;
    if (data_i.rem >= trial) begin
      data_d.rem  = data_i.rem - trial;
      data_d.root = (data_i.root >> 1) + Bit;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire
